// File: sv/fobt_pkg.sv
// Shared types and constants for the framed on/off bit transmitter.
package fobt_pkg;

    localparam int unsigned MAX_LEN_DEF = 256;

    localparam logic [31:0] SYNC_PAT_RST     = 32'd0;
    localparam logic [31:0] SLOT_TICKS_RST   = 32'd500;
    localparam logic [31:0] GAP_TICKS_RST    = 32'd20000;
    localparam logic [31:0] REPEAT_COUNT_RST = 32'd1;

    localparam logic [4:0] SYNC_MSB = 5'd31;
    localparam logic [4:0] LEN_MSB  = 5'd15;
    localparam logic [4:0] BYTE_MSB = 5'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GAP,
        PH_SYNC,
        PH_LEN,
        PH_DATA,
        PH_CSUM
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_LOAD,
        KIND_START,
        KIND_TICK
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SYNC_PAT,
        CFG_SLOT_TICKS,
        CFG_GAP_TICKS,
        CFG_REPEAT_COUNT
    } cfg_idx_t;

    typedef struct packed {
        logic       line_active;
        logic       busy_res;
        logic       frame_done;
        logic       all_done;
        logic       rejected;
    } result_t;

endpackage

// File: sv/fobt_payload_buf.sv
// Payload byte buffer: one write port, one registered read port.
module fobt_payload_buf #(
    parameter int unsigned MAX_LEN = fobt_pkg::MAX_LEN_DEF,
    parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/framed_onoff_bit_transmitter.sv
// The result of an accepted item is registered and shown on the m_ side in the next cycle.
// Throughput: one item per cycle while m_tready is high; the result register frees as it is taken.
// Sync bits are picked from the sync register by bit position, so a write lands at once.
// Length, payload and checksum bits leave one shift register, one bit per bit slot.
// Payload bytes are prefetched from the buffer's registered read port.
// Reset (aresetn low, synchronous): registers to defaults, payload empty, idle.
module framed_onoff_bit_transmitter #(
    parameter int unsigned MAX_LEN = fobt_pkg::MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line_active, busy_res, all_done, rejected, zero fill
    output logic        m_tlast,   // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    logic [31:0] sync_pat_reg;
    logic [31:0] slot_ticks_reg;
    logic [31:0] gap_ticks_reg;
    logic [31:0] repeat_count_reg;

    fobt_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [7:0]       csum_reg, csum_next;
    logic [31:0]      shift_reg, shift_next;
    logic [4:0]       bits_reg, bits_next;
    logic [CW-1:0]    next_idx_reg, next_idx_next;
    logic [31:0]      tick_cnt_reg, tick_cnt_next;
    logic [31:0]      frames_reg, frames_next;

    logic             m_tvalid_reg, m_tvalid_next;
    fobt_pkg::result_t res_reg, res_next;

    logic             s_accept;
    logic             busy;
    fobt_pkg::kind_t  kind;
    logic             wr_en;
    logic [7:0]       rd_data;
    logic [31:0]      tick_inc;
    logic [31:0]      slot_lim;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign busy      = (phase_reg != fobt_pkg::PH_IDLE);
    assign kind      = fobt_pkg::kind_t'(s_tuser);
    assign tick_inc  = tick_cnt_reg + 32'd1;
    assign slot_lim  = (slot_ticks_reg == 32'd0) ? 32'd1 : slot_ticks_reg;

    fobt_payload_buf #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (next_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_pat_reg     <= fobt_pkg::SYNC_PAT_RST;
            slot_ticks_reg   <= fobt_pkg::SLOT_TICKS_RST;
            gap_ticks_reg    <= fobt_pkg::GAP_TICKS_RST;
            repeat_count_reg <= fobt_pkg::REPEAT_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (fobt_pkg::cfg_idx_t'(cfg_index))
                fobt_pkg::CFG_SYNC_PAT:     sync_pat_reg     <= cfg_data;
                fobt_pkg::CFG_SLOT_TICKS:   slot_ticks_reg   <= cfg_data;
                fobt_pkg::CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_data;
                fobt_pkg::CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= fobt_pkg::PH_IDLE;
            count_reg    <= '0;
            csum_reg     <= '0;
            bits_reg     <= '0;
            next_idx_reg <= '0;
            tick_cnt_reg <= '0;
            frames_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            csum_reg     <= csum_next;
            bits_reg     <= bits_next;
            next_idx_reg <= next_idx_next;
            tick_cnt_reg <= tick_cnt_next;
            frames_reg   <= frames_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        csum_next     = csum_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        next_idx_next = next_idx_reg;
        tick_cnt_next = tick_cnt_reg;
        frames_next   = frames_reg;
        wr_en         = 1'b0;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (s_accept) begin
            m_tvalid_next        = 1'b1;
            res_next             = '0;
            res_next.line_active = busy && (phase_reg != fobt_pkg::PH_GAP) &&
                                   ((phase_reg == fobt_pkg::PH_SYNC) ? sync_pat_reg[bits_reg]
                                                                     : shift_reg[31]);

            case (kind)
                fobt_pkg::KIND_CLEAR: begin
                    if (busy) begin
                        res_next.rejected = 1'b1;
                    end else begin
                        count_next = '0;
                        csum_next  = '0;
                    end
                end
                fobt_pkg::KIND_LOAD: begin
                    if (busy || (count_reg == CW'(MAX_LEN))) begin
                        res_next.rejected = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        csum_next  = csum_reg ^ s_tdata;
                        count_next = count_reg + CW'(1);
                    end
                end
                fobt_pkg::KIND_START: begin
                    if (busy) begin
                        res_next.rejected = 1'b1;
                    end else if (repeat_count_reg != 32'd0) begin
                        frames_next   = repeat_count_reg;
                        phase_next    = fobt_pkg::PH_SYNC;
                        bits_next     = fobt_pkg::SYNC_MSB;
                        tick_cnt_next = '0;
                        next_idx_next = '0;
                    end
                end
                fobt_pkg::KIND_TICK: begin
                    if (phase_reg == fobt_pkg::PH_GAP) begin
                        if (tick_inc >= gap_ticks_reg) begin
                            phase_next    = fobt_pkg::PH_SYNC;
                            bits_next     = fobt_pkg::SYNC_MSB;
                            tick_cnt_next = '0;
                            next_idx_next = '0;
                        end else begin
                            tick_cnt_next = tick_inc;
                        end
                    end else if (busy) begin
                        if (tick_inc >= slot_lim) begin
                            tick_cnt_next = '0;
                            if (bits_reg != 5'd0) begin
                                bits_next  = bits_reg - 5'd1;
                                shift_next = {shift_reg[30:0], 1'b0};
                            end else begin
                                case (phase_reg)
                                    fobt_pkg::PH_SYNC: begin
                                        phase_next = fobt_pkg::PH_LEN;
                                        bits_next  = fobt_pkg::LEN_MSB;
                                        shift_next = {16'(count_reg), 16'd0};
                                    end
                                    fobt_pkg::PH_LEN: begin
                                        bits_next = fobt_pkg::BYTE_MSB;
                                        if (count_reg != '0) begin
                                            phase_next    = fobt_pkg::PH_DATA;
                                            shift_next    = {rd_data, 24'd0};
                                            next_idx_next = CW'(1);
                                        end else begin
                                            phase_next = fobt_pkg::PH_CSUM;
                                            shift_next = {csum_reg, 24'd0};
                                        end
                                    end
                                    fobt_pkg::PH_DATA: begin
                                        bits_next = fobt_pkg::BYTE_MSB;
                                        if (next_idx_reg >= count_reg) begin
                                            phase_next = fobt_pkg::PH_CSUM;
                                            shift_next = {csum_reg, 24'd0};
                                        end else begin
                                            shift_next    = {rd_data, 24'd0};
                                            next_idx_next = next_idx_reg + CW'(1);
                                        end
                                    end
                                    fobt_pkg::PH_CSUM: begin
                                        res_next.frame_done = 1'b1;
                                        if (frames_reg <= 32'd1) begin
                                            frames_next       = '0;
                                            phase_next        = fobt_pkg::PH_IDLE;
                                            res_next.all_done = 1'b1;
                                        end else begin
                                            frames_next = frames_reg - 32'd1;
                                            if (gap_ticks_reg != 32'd0) begin
                                                phase_next = fobt_pkg::PH_GAP;
                                            end else begin
                                                phase_next    = fobt_pkg::PH_SYNC;
                                                bits_next     = fobt_pkg::SYNC_MSB;
                                                next_idx_next = '0;
                                            end
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end else begin
                            tick_cnt_next = tick_inc;
                        end
                    end
                end
                default: ;
            endcase

            res_next.busy_res = (phase_next != fobt_pkg::PH_IDLE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {4'd0, res_reg.rejected, res_reg.all_done,
                       res_reg.busy_res, res_reg.line_active};

    a_all_done_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && res_reg.all_done) |-> res_reg.frame_done)
        else $error("all_done without frame_done");

    a_idle_no_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == fobt_pkg::PH_IDLE) |-> (frames_reg == 32'd0))
        else $error("frames left while idle");

    a_busy_load_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && busy && (kind == fobt_pkg::KIND_LOAD)) |=> res_reg.rejected)
        else $error("load while busy not rejected");

    a_len_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == fobt_pkg::PH_LEN) |-> (bits_reg <= fobt_pkg::LEN_MSB))
        else $error("length field bit position out of range");

endmodule
